FILE: hw/rtl/stunp_pkg.sv
// ----------------------------------------------------------------------------
// stunp_pkg: shared types and constants of the binding response parser
// Sizes, protocol codes, and the request and result records that pass between
// the front end, the queues and the attribute walker.
// ----------------------------------------------------------------------------
package stunp_pkg;

  localparam int MAX_PACKET = 512;
  localparam int CNT_W      = $clog2(MAX_PACKET + 1);
  localparam int POS_W      = $clog2(MAX_PACKET);
  localparam int HDR_BYTES  = 20;
  localparam int OFF_W      = 17;

  localparam int REQ_Q_DEPTH = 4;
  localparam int REQ_PTR_W   = $clog2(REQ_Q_DEPTH);
  localparam int RES_Q_DEPTH = 2;
  localparam int RES_PTR_W   = $clog2(RES_Q_DEPTH);

  localparam logic [15:0] TYPE_MASK       = 16'h0110;
  localparam logic [15:0] TYPE_SUCCESS    = 16'h0100;
  localparam logic [15:0] ATTR_XOR_MAPPED = 16'h0020;
  localparam logic [15:0] ATTR_MAPPED     = 16'h0001;
  localparam logic [15:0] PORT_COOKIE     = 16'h2112;
  localparam logic [31:0] ADDR_COOKIE     = 32'h2112A442;
  localparam logic [7:0]  FAMILY_IPV4     = 8'h01;

  typedef enum logic [1:0] {
    ST_FOUND       = 2'd0,
    ST_SHORT       = 2'd1,
    ST_NOT_SUCCESS = 2'd2,
    ST_NO_ADDR     = 2'd3
  } status_t;

  // One datagram byte, tagged by the front end
  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             drop;    // past MAX_PACKET, only the end marker matters
    logic             hdr;     // inside the fixed header
    logic             type_hi; // message type, high byte
    logic             type_lo; // message type, low byte
    logic [POS_W-1:0] pos;
    logic [CNT_W-1:0] cnt;     // bytes kept so far, this one included
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] addr;
    logic [15:0] port;
    logic        xor_form;
  } res_t;

endpackage

FILE: hw/rtl/stunp_front.sv
// ----------------------------------------------------------------------------
// stunp_front: byte intake and classification
// Counts datagram bytes, tags each one with its position and header role,
// and drops bytes beyond MAX_PACKET except for the end marker.
// ----------------------------------------------------------------------------
module stunp_front import stunp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       q_full,
  output logic       full,
  output logic       req_push,
  output req_t       req
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             drop;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign drop   = (cnt_r == CNT_W'(MAX_PACKET));

  always_comb begin
    req.data    = data_byte;
    req.last    = last_byte;
    req.drop    = drop;
    req.hdr     = (cnt_r < CNT_W'(HDR_BYTES));
    req.type_hi = (cnt_r == CNT_W'(0));
    req.type_lo = (cnt_r == CNT_W'(1));
    req.pos     = cnt_r[POS_W-1:0];
    req.cnt     = drop ? cnt_r : cnt_r + 1'b1;

    req_push = accept && (!drop || last_byte);

    cnt_nxt = cnt_r;
    if (accept) begin
      if (last_byte) cnt_nxt = '0;
      else           cnt_nxt = req.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

endmodule

FILE: hw/rtl/stunp_req_q.sv
// ----------------------------------------------------------------------------
// stunp_req_q: request queue between front end and walker
// Four entries of tagged bytes, so that either side can stall alone.
// ----------------------------------------------------------------------------
module stunp_req_q import stunp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  req_t wr_data,
  input  logic rd_en,
  output req_t rd_data,
  output logic full,
  output logic empty
);

  req_t                       mem [REQ_Q_DEPTH];
  logic [REQ_PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [$clog2(REQ_Q_DEPTH+1)-1:0] count_r;
  logic                       do_wr, do_rd;

  assign full    = (count_r == ($bits(count_r))'(REQ_Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/stunp_walk.sv
// ----------------------------------------------------------------------------
// stunp_walk: attribute walker
// Tracks the message type, steps over padded attributes and captures the
// first usable IPv4 address attribute; builds the result at the last byte.
// ----------------------------------------------------------------------------
module stunp_walk import stunp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  req_t req,
  input  logic res_full,
  output logic req_pop,
  output logic res_push,
  output res_t res
);

  logic [15:0]      msg_r, msg_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;   // offset inside the current attribute
  logic [15:0]      akind_r, akind_nxt;
  logic [15:0]      asize_r, asize_nxt;
  logic [7:0]       family_r, family_nxt;
  logic [15:0]      cport_r, cport_nxt;
  logic [31:0]      caddr_r, caddr_nxt;
  logic             cxor_r, cxor_nxt;
  logic [OFF_W-1:0] cend_r, cend_nxt;
  logic             cvalid_r, cvalid_nxt;

  logic             go, work, usable, take, found;
  logic [OFF_W-1:0] padded;

  // hold the end byte while the result queue is full
  assign go       = req_valid && (!req.last || !res_full);
  assign req_pop  = go;
  assign res_push = go && req.last;
  assign work     = go && !req.drop;
  assign usable   = ((akind_r == ATTR_XOR_MAPPED) || (akind_r == ATTR_MAPPED)) &&
                    (asize_r >= 16'd8);

  always_comb begin
    msg_nxt    = msg_r;
    off_nxt    = off_r;
    akind_nxt  = akind_r;
    asize_nxt  = asize_r;
    family_nxt = family_r;
    cport_nxt  = cport_r;
    caddr_nxt  = caddr_r;
    cxor_nxt   = cxor_r;
    cend_nxt   = cend_r;
    cvalid_nxt = cvalid_r;
    take       = 1'b0;
    padded     = '0;

    if (work) begin
      if (req.type_hi) msg_nxt[15:8] = req.data;
      if (req.type_lo) msg_nxt[7:0]  = req.data;

      if (!req.hdr && !cvalid_r) begin
        if (off_r == OFF_W'(0))      akind_nxt[15:8] = req.data;
        else if (off_r == OFF_W'(1)) akind_nxt[7:0]  = req.data;
        else if (off_r == OFF_W'(2)) asize_nxt[15:8] = req.data;
        else if (off_r == OFF_W'(3)) asize_nxt[7:0]  = req.data;
        else if (usable && off_r < OFF_W'(12)) begin
          if (off_r == OFF_W'(5))      family_nxt      = req.data;
          else if (off_r == OFF_W'(6)) cport_nxt[15:8] = req.data;
          else if (off_r == OFF_W'(7)) cport_nxt[7:0]  = req.data;
          else if (off_r >= OFF_W'(8)) begin
            caddr_nxt = {caddr_r[23:0], req.data};
            if (off_r == OFF_W'(11) && family_r == FAMILY_IPV4) begin
              take       = 1'b1;
              cxor_nxt   = (akind_r == ATTR_XOR_MAPPED);
              if (cxor_nxt) begin
                cport_nxt = cport_r ^ PORT_COOKIE;
                caddr_nxt = caddr_nxt ^ ADDR_COOKIE;
              end
              // attribute began eleven bytes back: end = start + 4 + size
              cend_nxt   = OFF_W'(req.pos) + OFF_W'(asize_r) - OFF_W'(7);
              cvalid_nxt = 1'b1;
            end
          end
        end

        padded = (OFF_W'(asize_nxt) + OFF_W'(3)) & ~OFF_W'(3);
        if (!take) begin
          // advance to the next attribute after its padded value
          if (off_r == padded + OFF_W'(3)) off_nxt = '0;
          else                             off_nxt = off_r + 1'b1;
        end
      end
    end

    found = cvalid_nxt && (cend_nxt <= OFF_W'(req.cnt));

    res.addr     = '0;
    res.port     = '0;
    res.xor_form = 1'b0;
    if (req.cnt < CNT_W'(HDR_BYTES))                res.status = ST_SHORT;
    else if ((msg_nxt & TYPE_MASK) != TYPE_SUCCESS) res.status = ST_NOT_SUCCESS;
    else if (found) begin
      res.status   = ST_FOUND;
      res.addr     = caddr_nxt;
      res.port     = cport_nxt;
      res.xor_form = cxor_nxt;
    end else                                        res.status = ST_NO_ADDR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || res_push) begin
      off_r    <= '0;
      cvalid_r <= 1'b0;
    end else begin
      off_r    <= off_nxt;
      cvalid_r <= cvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r    <= msg_nxt;
    akind_r  <= akind_nxt;
    asize_r  <= asize_nxt;
    family_r <= family_nxt;
    cport_r  <= cport_nxt;
    caddr_r  <= caddr_nxt;
    cxor_r   <= cxor_nxt;
    cend_r   <= cend_nxt;
  end

endmodule

FILE: hw/rtl/stunp_res_q.sv
// ----------------------------------------------------------------------------
// stunp_res_q: result queue
// Holds finished results until the receiver pops them.
// ----------------------------------------------------------------------------
module stunp_res_q import stunp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  res_t wr_data,
  input  logic rd_en,
  output res_t rd_data,
  output logic full,
  output logic empty
);

  res_t                             mem [RES_Q_DEPTH];
  logic [RES_PTR_W-1:0]             wr_ptr_r, rd_ptr_r;
  logic [$clog2(RES_Q_DEPTH+1)-1:0] count_r;
  logic                             do_wr, do_rd;

  assign full    = (count_r == ($bits(count_r))'(RES_Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd)      count_r <= count_r + 1'b1;
      else if (do_rd && !do_wr) count_r <= count_r - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/stun_binding_response_parser.sv
// ----------------------------------------------------------------------------
// stun_binding_response_parser: binding response address extraction
// Input queue side: push a datagram byte with in_last_byte on its final byte;
// a request is taken at a clock edge with push high and full low.
// Result queue side: while empty is low the oldest result (status, mapped
// address, mapped port, XOR flag) is on the out_ ports; pop takes it.
// One result is produced per datagram, at its marked last byte.
// Throughput: one byte per clock while the result queue has room, set by the
// attribute walker, which retires one queued byte each cycle unless it must
// hold an end byte. A result reaches out_ ports via the request queue, the
// walker and the result queue; earlier queued bytes are walked first.
// A four-entry request queue sits between intake and walker, a two-entry
// result queue at the output. When the receiver stalls, the walker holds the
// end byte of the next datagram until a result slot frees; other bytes keep
// flowing until the request queue fills and full rises.
// Bytes beyond MAX_PACKET are dropped; their end marker still closes the
// datagram. Synchronous reset empties both queues and clears the byte count.
// ----------------------------------------------------------------------------
module stun_binding_response_parser import stunp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_status,
  output logic [31:0] out_mapped_address,
  output logic [15:0] out_mapped_port,
  output logic        out_was_xor_form
);

  req_t front_req, walk_req;
  res_t walk_res, head_res;
  logic front_push, req_full, req_empty, req_pop;
  logic res_push, res_full;

  stunp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .q_full    (req_full),
    .full      (full),
    .req_push  (front_push),
    .req       (front_req)
  );

  stunp_req_q u_req_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_push),
    .wr_data (front_req),
    .rd_en   (req_pop),
    .rd_data (walk_req),
    .full    (req_full),
    .empty   (req_empty)
  );

  stunp_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (!req_empty),
    .req       (walk_req),
    .res_full  (res_full),
    .req_pop   (req_pop),
    .res_push  (res_push),
    .res       (walk_res)
  );

  stunp_res_q u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (walk_res),
    .rd_en   (pop),
    .rd_data (head_res),
    .full    (res_full),
    .empty   (empty)
  );

  assign out_status         = head_res.status;
  assign out_mapped_address = head_res.addr;
  assign out_mapped_port    = head_res.port;
  assign out_was_xor_form   = head_res.xor_form;

endmodule

FILE: hw/rtl/stunp_checker.sv
// ----------------------------------------------------------------------------
// stunp_checker: port-level checks of the binding response parser
// Reset state of both queues, zeroed payload on failure results, and result
// hold while the receiver stalls.
// ----------------------------------------------------------------------------
module stunp_checker import stunp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  out_status,
  input logic [31:0] out_mapped_address,
  input logic [15:0] out_mapped_port,
  input logic        out_was_xor_form
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_fail_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != ST_FOUND) |->
      (out_mapped_address == 32'd0 && out_mapped_port == 16'd0 && !out_was_xor_form))
    else $error("address fields set on a failure result");

  a_result_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("result vanished without pop");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_status) && $stable(out_mapped_address) &&
                          $stable(out_mapped_port) && $stable(out_was_xor_form)))
    else $error("stalled result changed");

endmodule

bind stun_binding_response_parser stunp_checker u_stunp_checker (.*);

FILE: dv/stun_binding_response_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stun_binding_response_parser_tb: self-checking bench for the binding parser
// Streams whole datagrams through the byte queue and predicts each result
// with a behavioral walker of the header and attributes. A short table of
// datagrams covers the edge cases, then random responses and noise follow.
// Both queue sides idle at random.
// ----------------------------------------------------------------------------
module stun_binding_response_parser_tb;
  import stunp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DGRAM_CAP    = 700;
  localparam int RANDOM_BYTES = 500;
  localparam int SETTLE_WAIT  = 10;
  localparam int REPORT_MAX   = 10;

  localparam logic [15:0] ATTR_SOFTWARE = 16'h8022;
  localparam logic [15:0] TYPE_BIND_OK  = 16'h0101;
  localparam logic [15:0] TYPE_BIND_ERR = 16'h0111;
  localparam logic [15:0] TYPE_BIND_REQ = 16'h0001;

  typedef struct {
    logic [15:0] mtype;
    bit          typed;     // status column is used only on typed rows
    status_t     st;
    int unsigned total;     // 0 keeps the natural length
    bit          has_pre;
    logic [15:0] pre_kind;
    logic [15:0] pre_len;
    logic [7:0]  pre_fam;
    bit          has_addr;
    logic [15:0] akind;
    logic [15:0] alen;
    logic [7:0]  fam;
    logic [15:0] port;
    logic [31:0] addr;
  } dgram_case_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_mapped_address;
  logic [15:0] out_mapped_port;
  logic        out_was_xor_form;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stun_binding_response_parser i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_data_byte       (in_data_byte),
    .in_last_byte       (in_last_byte),
    .empty              (empty),
    .pop                (pop),
    .out_status         (out_status),
    .out_mapped_address (out_mapped_address),
    .out_mapped_port    (out_mapped_port),
    .out_was_xor_form   (out_was_xor_form)
  );

  // Walker state of the predictor
  logic [9:0]  seen_cnt;
  logic [15:0] type_seen;
  logic [16:0] attr_base;
  logic [15:0] kind_seen;
  logic [15:0] len_seen;
  logic [7:0]  fam_seen;
  logic [15:0] cand_port;
  logic [31:0] cand_addr;
  logic        cand_xor;
  logic [16:0] cand_limit;
  logic        cand_ok;

  res_t        pending_results[$];
  dgram_case_t plan[$];
  logic [7:0]  dgram[$];
  bit          calm = 1'b0;
  int          bytes_sent = 0;
  int          dgrams_sent = 0;
  int          mismatches = 0;
  int          status_tally[4] = '{0, 0, 0, 0};
  int          cycle_cnt = 0;

  function automatic void clear_walk();
    seen_cnt   = '0;
    type_seen  = '0;
    attr_base  = 17'(HDR_BYTES);
    kind_seen  = '0;
    len_seen   = '0;
    fam_seen   = '0;
    cand_port  = '0;
    cand_addr  = '0;
    cand_xor   = 1'b0;
    cand_limit = '0;
    cand_ok    = 1'b0;
  endfunction

  function automatic void walk_byte(int unsigned pos, logic [7:0] b);
    int unsigned r;
    int unsigned k;
    int unsigned padded;
    bit          usable;
    if (pos == 0) type_seen[15:8] = b;
    if (pos == 1) type_seen[7:0] = b;
    if (cand_ok || pos < attr_base) return;
    r = pos - attr_base;
    if (r == 0) begin
      kind_seen[15:8] = b;
    end else if (r == 1) begin
      kind_seen[7:0] = b;
    end else if (r == 2) begin
      len_seen[15:8] = b;
    end else if (r == 3) begin
      len_seen[7:0] = b;
    end else begin
      k = r - 4;
      usable = (kind_seen == ATTR_XOR_MAPPED || kind_seen == ATTR_MAPPED) && len_seen >= 8;
      if (usable && k < 8) begin
        if (k == 1) begin
          fam_seen = b;
        end else if (k == 2) begin
          cand_port[15:8] = b;
        end else if (k == 3) begin
          cand_port[7:0] = b;
        end else if (k >= 4) begin
          cand_addr = {cand_addr[23:0], b};
          if (k == 7 && fam_seen == FAMILY_IPV4) begin
            cand_xor = (kind_seen == ATTR_XOR_MAPPED);
            if (cand_xor) begin
              cand_port = cand_port ^ PORT_COOKIE;
              cand_addr = cand_addr ^ ADDR_COOKIE;
            end
            cand_limit = attr_base + 17'd4 + {1'b0, len_seen};
            cand_ok = 1'b1;
            return;
          end
        end
      end
    end
    // advance to the next attribute once the padded value is consumed
    if (r >= 3) begin
      padded = (32'(len_seen) + 32'd3) & 32'hFFFF_FFFC;
      if (r == 3 + padded) attr_base = attr_base + 17'(4 + padded);
    end
  endfunction

  function automatic bit predict_reply(input logic [7:0] b, input logic l, output res_t reply);
    reply = '0;
    if (seen_cnt < MAX_PACKET) begin
      walk_byte(seen_cnt, b);
      seen_cnt++;
    end
    if (!l) return 1'b0;
    if (seen_cnt < HDR_BYTES) begin
      reply.status = ST_SHORT;
    end else if ((type_seen & TYPE_MASK) != TYPE_SUCCESS) begin
      reply.status = ST_NOT_SUCCESS;
    end else if (cand_ok && cand_limit <= seen_cnt) begin
      reply.status   = ST_FOUND;
      reply.addr     = cand_addr;
      reply.port     = cand_port;
      reply.xor_form = cand_xor;
    end else begin
      reply.status = ST_NO_ADDR;
    end
    clear_walk();
    return 1'b1;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    if (dgram.size() < DGRAM_CAP) dgram.push_back(b);
  endfunction

  function automatic void start_dgram(logic [15:0] mtype);
    dgram.delete();
    put_byte(mtype[15:8]);
    put_byte(mtype[7:0]);
    // length field is random: the parser ignores it
    put_byte(8'($urandom));
    put_byte(8'($urandom));
    for (int i = 3; i >= 0; i--) put_byte(ADDR_COOKIE[8*i +: 8]);
    repeat (12) put_byte(8'($urandom));
  endfunction

  function automatic void add_attr(logic [15:0] kind, logic [15:0] len, logic [7:0] fam,
                                   logic [15:0] port, logic [31:0] addr);
    logic [15:0] wire_port;
    logic [31:0] wire_addr;
    int unsigned n;
    wire_port = port;
    wire_addr = addr;
    if (kind == ATTR_XOR_MAPPED) begin
      wire_port = port ^ PORT_COOKIE;
      wire_addr = addr ^ ADDR_COOKIE;
    end
    put_byte(kind[15:8]);
    put_byte(kind[7:0]);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    n = (32'(len) + 32'd3) & 32'hFFFF_FFFC;
    for (int unsigned i = 0; i < n && dgram.size() < DGRAM_CAP; i++) begin
      case (i)
        1:       put_byte(fam);
        2:       put_byte(wire_port[15:8]);
        3:       put_byte(wire_port[7:0]);
        4:       put_byte(wire_addr[31:24]);
        5:       put_byte(wire_addr[23:16]);
        6:       put_byte(wire_addr[15:8]);
        7:       put_byte(wire_addr[7:0]);
        default: put_byte(8'($urandom));
      endcase
    end
  endfunction

  function automatic void fit_length(int unsigned total);
    if (total == 0) return;
    while (dgram.size() > total) void'(dgram.pop_back());
    while (dgram.size() < total) dgram.push_back(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic l, output bit got, output res_t pred);
    while (!calm && $urandom_range(0, 99) < 8) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= l;
    // hold the request until full drops
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    if (seen_cnt < MAX_PACKET) bytes_sent++;
    got = predict_reply(b, l, pred);
  endtask

  task automatic send_dgram(input bit typed, input res_t typed_exp);
    bit   got;
    res_t pred;
    foreach (dgram[i]) begin
      send_byte(dgram[i], i == dgram.size() - 1, got, pred);
      if (got) pending_results.push_back(typed ? typed_exp : pred);
    end
    dgrams_sent++;
  endtask

  task automatic random_dgram();
    int unsigned mode;
    int unsigned pick;
    int unsigned cut;
    logic [15:0] mtype;
    logic [15:0] kind;
    logic [15:0] len;
    logic [7:0]  fam;
    mode  = $urandom_range(0, 99);
    mtype = 16'($urandom);
    if (mode >= 95) begin
      start_dgram(mtype);
      fit_length($urandom_range(1, HDR_BYTES - 1));
      return;
    end
    if (mode >= 85) begin
      dgram.delete();
      repeat ($urandom_range(1, 48)) put_byte(8'($urandom));
      return;
    end
    if (mode < 70) mtype = (mtype & ~TYPE_MASK) | TYPE_SUCCESS;
    start_dgram(mtype);
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(0, 9);
      kind = (pick < 4) ? ATTR_XOR_MAPPED : (pick < 7) ? ATTR_MAPPED :
             (pick < 9) ? 16'($urandom) : ATTR_SOFTWARE;
      pick = $urandom_range(0, 19);
      if (pick < 12)      len = 16'd8;
      else if (pick < 16) len = 16'($urandom_range(0, 7));
      else if (pick < 19) len = 16'($urandom_range(9, 24));
      else if ($urandom_range(0, 3) == 0) len = 16'($urandom);
      else len = 16'($urandom_range(25, 60));
      fam = ($urandom_range(0, 9) < 7) ? FAMILY_IPV4 : 8'($urandom);
      add_attr(kind, len, fam, 16'($urandom), $urandom);
    end
    pick = $urandom_range(0, 9);
    if (pick == 7) begin
      cut = $urandom_range(1, 8);
      if (cut < dgram.size()) fit_length(dgram.size() - cut);
    end else if (pick == 8) begin
      fit_length(dgram.size() + $urandom_range(1, 8));
    end else if (pick == 9) begin
      fit_length($urandom_range(1, dgram.size()));
    end
  endtask

  always @(posedge clk) begin
    pop <= calm || ($urandom_range(0, 99) >= 8);
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && pop && !empty) begin
      status_tally[out_status]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: status %0d addr %h port %h xor %0d",
                   out_status, out_mapped_address, out_mapped_port, out_was_xor_form);
      end else begin
        want = pending_results.pop_front();
        if (want.status !== status_t'(out_status) || want.addr !== out_mapped_address ||
            want.port !== out_mapped_port || want.xor_form !== out_was_xor_form) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("mismatch: status %0d/%0d addr %h/%h port %h/%h xor %0d/%0d (exp/got)",
                     want.status, out_status, want.addr, out_mapped_address,
                     want.port, out_mapped_port, want.xor_form, out_was_xor_form);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    dgram_case_t row;
    res_t        typed_exp;
    int          dir_bytes;
    int          n_rand;
    clear_walk();
    // mtype, typed, status, total | pre: on, kind, len, fam | addr: on, kind, len, fam, port, addr
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 1, ST_SHORT, 1,
      0, 16'h0, 16'd0, 8'h0, 0, 16'h0, 16'd0, 8'h0, 16'h0, 32'h0});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 1, ST_SHORT, 19,
      0, 16'h0, 16'd0, 8'h0, 0, 16'h0, 16'd0, 8'h0, 16'h0, 32'h0});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 1, ST_NO_ADDR, 0,
      0, 16'h0, 16'd0, 8'h0, 0, 16'h0, 16'd0, 8'h0, 16'h0, 32'h0});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 1, ST_FOUND, 0,
      0, 16'h0, 16'd0, 8'h0, 1, ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'hFFFF, 32'hFFFF_FFFF});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 1, ST_FOUND, 0,
      0, 16'h0, 16'd0, 8'h0, 1, ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0000, 32'h0000_0000});
    plan.push_back(dgram_case_t'{TYPE_BIND_ERR, 1, ST_NOT_SUCCESS, 0,
      0, 16'h0, 16'd0, 8'h0, 1, ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h1234, 32'hC0A8_0001});
    plan.push_back(dgram_case_t'{TYPE_BIND_REQ, 1, ST_NOT_SUCCESS, 0,
      0, 16'h0, 16'd0, 8'h0, 1, ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'h4321, 32'h0A00_0001});
    plan.push_back(dgram_case_t'{16'hFFFF, 1, ST_NOT_SUCCESS, 0,
      0, 16'h0, 16'd0, 8'h0, 1, ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h8000, 32'h8000_0000});
    plan.push_back(dgram_case_t'{16'hFFEF, 0, ST_FOUND, 0,
      0, 16'h0, 16'd0, 8'h0, 1, ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0001, 32'h7F00_0001});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 1, ST_NO_ADDR, 0,
      0, 16'h0, 16'd0, 8'h0, 1, ATTR_XOR_MAPPED, 16'd20, 8'h02, 16'h1111, 32'h2222_3333});
    // IPv6 address attribute skipped, the IPv4 one behind it taken
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 0,
      1, ATTR_MAPPED, 16'd20, 8'h02, 1, ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'hBEEF, 32'h5566_7788});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 0,
      1, ATTR_XOR_MAPPED, 16'd4, FAMILY_IPV4, 1, ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0050,
      32'hAC10_0A01});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 0,
      1, ATTR_SOFTWARE, 16'd5, 8'h00, 1, ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0D96, 32'h0102_0304});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 0,
      1, ATTR_MAPPED, 16'd8, 8'hFF, 1, ATTR_XOR_MAPPED, 16'd12, FAMILY_IPV4, 16'hA5A5, 32'h5A5A_A5A5});
    // declared value runs past the end of the datagram
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 32,
      0, 16'h0, 16'd0, 8'h0, 1, ATTR_XOR_MAPPED, 16'd12, FAMILY_IPV4, 16'h1357, 32'h2468_ACE0});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 64,
      1, ATTR_SOFTWARE, 16'hFFFF, 8'h00, 1, ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0101,
      32'h0101_0101});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 64,
      0, 16'h0, 16'd0, 8'h0, 1, ATTR_XOR_MAPPED, 16'hFFFF, FAMILY_IPV4, 16'h0202, 32'h0202_0202});
    // oversize datagrams: the tail bytes and the end marker past the limit
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 520,
      1, ATTR_SOFTWARE, 16'd16, 8'h00, 1, ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'hC350,
      32'hCB00_7101});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 520,
      1, ATTR_SOFTWARE, 16'd488, 8'h00, 1, ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0303,
      32'h0303_0303});
    plan.push_back(dgram_case_t'{TYPE_BIND_OK, 0, ST_FOUND, 0,
      1, ATTR_XOR_MAPPED, 16'd8, FAMILY_IPV4, 1, ATTR_MAPPED, 16'd8, FAMILY_IPV4, 16'h0404,
      32'h0404_0404});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      row = plan[i];
      start_dgram(row.mtype);
      if (row.has_pre) add_attr(row.pre_kind, row.pre_len, row.pre_fam, 16'($urandom), $urandom);
      if (row.has_addr) add_attr(row.akind, row.alen, row.fam, row.port, row.addr);
      fit_length(row.total);
      typed_exp = '0;
      typed_exp.status = row.st;
      if (row.st == ST_FOUND) begin
        typed_exp.addr     = row.addr;
        typed_exp.port     = row.port;
        typed_exp.xor_form = (row.akind == ATTR_XOR_MAPPED);
      end
      send_dgram(row.typed, typed_exp);
    end

    dir_bytes = bytes_sent;
    n_rand = 0;
    typed_exp = '0;
    while (bytes_sent - dir_bytes < RANDOM_BYTES) begin
      calm = (n_rand >= 3 && n_rand < 9);
      random_dgram();
      send_dgram(1'b0, typed_exp);
      // drop push and let every result drain now and then
      if (n_rand % 4 == 2) begin
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      n_rand++;
    end
    calm = 1'b0;

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("covered %0d datagrams, %0d bytes kept, %0d mismatches", dgrams_sent, bytes_sent,
             mismatches);
    $display("results: found %0d, short %0d, not success %0d, no address %0d",
             status_tally[ST_FOUND], status_tally[ST_SHORT], status_tally[ST_NOT_SUCCESS],
             status_tally[ST_NO_ADDR]);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
